[hw/rtl/bbc_pkg.sv]
// Shared types, codes and decode functions for the bracket balance checker.
package bbc_pkg;

   typedef enum logic [1:0] {
      KIND_ROUND  = 2'd0,
      KIND_SQUARE = 2'd1,
      KIND_CURLY  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   // verdict codes on the response channel
   localparam logic [1:0] VERDICT_OPEN       = 2'd0;
   localparam logic [1:0] VERDICT_BALANCED   = 2'd1;
   localparam logic [1:0] VERDICT_UNBALANCED = 2'd2;

   localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28;
   localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;
   localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B;
   localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29;
   localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;
   localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_op_type;

   function automatic kind_type opener_kind(input logic [7:0] c);
      kind_type k;
      case (c)
         CHAR_OPEN_ROUND:  k = KIND_ROUND;
         CHAR_OPEN_SQUARE: k = KIND_SQUARE;
         CHAR_OPEN_CURLY:  k = KIND_CURLY;
         default:          k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic kind_type closer_kind(input logic [7:0] c);
      kind_type k;
      case (c)
         CHAR_CLOSE_ROUND:  k = KIND_ROUND;
         CHAR_CLOSE_SQUARE: k = KIND_SQUARE;
         CHAR_CLOSE_CURLY:  k = KIND_CURLY;
         default:           k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage

[hw/rtl/bbc_channels.sv]
// Valid/ready channel interfaces for the character and response transactions.
interface bbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       is_last;

   modport source (output valid, output char_code, output is_last, input ready);
   modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface bbc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] verdict;
   logic [7:0] depth;

   modport source (output valid, output verdict, output depth, input ready);
   modport sink   (input valid, input verdict, input depth, output ready);
endinterface

[hw/rtl/bracket_balance_checker_top.sv]
// The response is registered and shows on rsp_chan in the cycle after acceptance.
// Throughput: one character per cycle while responses are taken; the stack is a
// shift row of cells, top at cell 0. A new character gets in as the response is taken.
// Reset clears the depth count, the failure flag and the response valid; stack cells
// are not cleared and are only read below the depth count.
module bracket_balance_checker_top import bbc_pkg::*; #(
   parameter int STACK_DEPTH = 128
) (
   input logic       clock,
   input logic       reset,
   bbc_req_if.sink   req_chan,
   bbc_rsp_if.source rsp_chan
);

   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          failed_ff, failed_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_verdict_ff, rsp_verdict_in;
   logic [7:0]    rsp_depth_ff, rsp_depth_in;

   logic          accept;
   kind_type      open_kind;
   kind_type      close_kind;
   kind_type      top_kind;
   stack_op_type  op_next;
   stack_op_type  chain_op;
   logic [CW-1:0] count_next;
   logic          failed_next;
   logic [CW+7:0] depth_wide;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign open_kind  = opener_kind(req_chan.char_code);
   assign close_kind = closer_kind(req_chan.char_code);

   bbc_stack_chain #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_chain (
      .clock     (clock),
      .op        (chain_op),
      .push_kind (open_kind),
      .top_kind  (top_kind)
   );

   // stack step for the offered character
   always_comb begin
      op_next     = '0;
      count_next  = count_ff;
      failed_next = failed_ff;
      if (!failed_ff) begin
         if (open_kind != KIND_NONE) begin
            if (count_ff == CW'(STACK_DEPTH)) begin
               failed_next = 1'b1;
            end else begin
               op_next.push = 1'b1;
               count_next   = count_ff + 1'b1;
            end
         end else if (count_ff == '0) begin
            failed_next = 1'b1;
         end else begin
            op_next.pop = 1'b1;
            count_next  = count_ff - 1'b1;
            if (close_kind != top_kind) begin
               failed_next = 1'b1;
            end
         end
      end
   end

   assign chain_op.push = accept && op_next.push;
   assign chain_op.pop  = accept && op_next.pop;

   assign depth_wide = {8'b0, count_next};

   always_comb begin
      if (req_chan.is_last) begin
         rsp_verdict_in = (!failed_next && count_next == '0) ? VERDICT_BALANCED
                                                              : VERDICT_UNBALANCED;
      end else begin
         rsp_verdict_in = failed_next ? VERDICT_UNBALANCED : VERDICT_OPEN;
      end
      rsp_depth_in = depth_wide[7:0];
   end

   always_comb begin
      count_in     = count_ff;
      failed_in    = failed_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         // end of string: start the next one from an empty stack
         count_in     = req_chan.is_last ? '0 : count_next;
         failed_in    = req_chan.is_last ? 1'b0 : failed_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_verdict_ff <= rsp_verdict_in;
         rsp_depth_ff   <= rsp_depth_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.verdict = rsp_verdict_ff;
   assign rsp_chan.depth   = rsp_depth_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_fail_sticky : assert property (@(posedge clock) disable iff (reset)
      (accept && failed_ff && !req_chan.is_last) |=> (failed_ff && $stable(count_ff)))
      else $error("failure flag or count moved after failure");

   a_last_clears : assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.is_last) |=> (count_ff == '0 && !failed_ff))
      else $error("state not cleared after last character");

   a_balanced_empty : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_verdict_ff == VERDICT_BALANCED) |-> (rsp_depth_ff == 8'd0))
      else $error("balanced verdict with nonzero depth");

   a_push_counts : assert property (@(posedge clock) disable iff (reset)
      chain_op.push |=> (count_ff == $past(count_ff) + 1'b1 || $past(req_chan.is_last)))
      else $error("push without count increment");

endmodule

[hw/rtl/bbc_stack_cell.sv]
// One entry of the shift stack: takes its upper neighbor on push, lower on pop.
module bbc_stack_cell import bbc_pkg::*; (
   input  logic         clock,
   input  stack_op_type op,
   input  kind_type     from_above,
   input  kind_type     from_below,
   output kind_type     kind
);

   kind_type kind_ff;
   kind_type kind_in;

   always_comb begin
      kind_in = kind_ff;
      if (op.push) begin
         kind_in = from_above;
      end else if (op.pop) begin
         kind_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   assign kind = kind_ff;

endmodule

[hw/rtl/bbc_stack_chain.sv]
// Row of stack cells; cell 0 is the top of the stack.
module bbc_stack_chain import bbc_pkg::*; #(
   parameter int STACK_DEPTH = 128
) (
   input  logic         clock,
   input  stack_op_type op,
   input  kind_type     push_kind,
   output kind_type     top_kind
);

   kind_type cell_kind [STACK_DEPTH];

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      kind_type above;
      kind_type below;

      if (i == 0) begin : g_top
         assign above = push_kind;
      end else begin : g_mid
         assign above = cell_kind[i-1];
      end

      // bottom cell refills with a dead entry; it is never read before a push
      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign below = KIND_NONE;
      end else begin : g_inner
         assign below = cell_kind[i+1];
      end

      bbc_stack_cell u_cell (
         .clock      (clock),
         .op         (op),
         .from_above (above),
         .from_below (below),
         .kind       (cell_kind[i])
      );
   end

   assign top_kind = cell_kind[0];

endmodule

[test/bracket_verdict_checker.sv]
// Checker for the bracket balance checker: predicts each response and compares it on arrival.
module bracket_verdict_checker import bbc_pkg::*; #(
   parameter int STACK_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   bbc_req_if          req_mon,
   bbc_rsp_if          rsp_mon,
   output int unsigned fail_count,
   output int unsigned pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0] verdict;
      logic [7:0] depth;
   } verdict_type;

   verdict_type verdict_q[$];
   kind_type    open_stack[STACK_DEPTH];
   int unsigned open_count;
   bit          failed;

   // kind of a bracket byte; is_open tells opener from closer
   function automatic kind_type bracket_kind(input logic [7:0] c, output bit is_open);
      is_open = 1'b0;
      case (c)
         CHAR_OPEN_ROUND: begin
            is_open = 1'b1;
            return KIND_ROUND;
         end
         CHAR_OPEN_SQUARE: begin
            is_open = 1'b1;
            return KIND_SQUARE;
         end
         CHAR_OPEN_CURLY: begin
            is_open = 1'b1;
            return KIND_CURLY;
         end
         CHAR_CLOSE_ROUND:  return KIND_ROUND;
         CHAR_CLOSE_SQUARE: return KIND_SQUARE;
         CHAR_CLOSE_CURLY:  return KIND_CURLY;
         default:           return KIND_NONE;
      endcase
   endfunction

   task automatic advance_string(input logic [7:0] c, input logic last,
                                 output verdict_type v);
      kind_type k;
      bit       is_open;
      k = bracket_kind(c, is_open);
      if (!failed) begin
         if (is_open) begin
            if (open_count >= STACK_DEPTH) begin
               failed = 1'b1;
            end else begin
               open_stack[open_count] = k;
               open_count++;
            end
         end else if (open_count == 0) begin
            failed = 1'b1;
         end else begin
            open_count--;
            // non-bracket bytes carry KIND_NONE, which never sits on the stack
            if (k != open_stack[open_count]) failed = 1'b1;
         end
      end
      if (last) begin
         v.verdict = (!failed && open_count == 0) ? VERDICT_BALANCED : VERDICT_UNBALANCED;
      end else begin
         v.verdict = failed ? VERDICT_UNBALANCED : VERDICT_OPEN;
      end
      v.depth = open_count[7:0];
      if (last) begin
         open_count = 0;
         failed     = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      verdict_type got;
      verdict_type want;
      if (reset) begin
         verdict_q.delete();
         open_count = 0;
         failed     = 1'b0;
      end else begin
         // response first: a transaction accepted at this edge is not answered until the response register holds it
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.verdict = rsp_mon.verdict;
            got.depth   = rsp_mon.depth;
            if (verdict_q.size() == 0) begin
               $display("%0t unexpected response: expected none, got verdict %0d depth %0d",
                        $realtime, got.verdict, got.depth);
               fail_count++;
            end else begin
               want = verdict_q.pop_front();
               if (got.verdict !== want.verdict) begin
                  $display("%0t verdict mismatch: expected %0d, got %0d",
                           $realtime, want.verdict, got.verdict);
                  fail_count++;
               end
               if (got.depth !== want.depth) begin
                  $display("%0t depth mismatch: expected %0d, got %0d",
                           $realtime, want.depth, got.depth);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            advance_string(req_mon.char_code, req_mon.is_last, want);
            verdict_q.push_back(want);
         end
      end
      pending = verdict_q.size();
   end

endmodule

[test/tb_top.sv]
// Testbench top: clock, reset, character stimulus, response back-pressure and the verdict.
module tb_top import bbc_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_DEPTH = 128;
   localparam int ITEM_TARGET = 1900;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_last;
   } text_char_type;

   logic          clock;
   logic          reset;
   int unsigned   fail_count;
   int unsigned   pending;
   bit            calm;
   bit            hold_now;
   text_char_type text_q[$];

   bbc_req_if req_chan();
   bbc_rsp_if rsp_chan();

   bracket_balance_checker_top #(.STACK_DEPTH(STACK_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bracket_verdict_checker #(.STACK_DEPTH(STACK_DEPTH)) checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #800000;
      $display("tb_top failed");
      $finish;
   end

   function automatic logic [7:0] open_char(input kind_type k);
      case (k)
         KIND_ROUND:  return CHAR_OPEN_ROUND;
         KIND_SQUARE: return CHAR_OPEN_SQUARE;
         default:     return CHAR_OPEN_CURLY;
      endcase
   endfunction

   function automatic logic [7:0] close_char(input kind_type k);
      case (k)
         KIND_ROUND:  return CHAR_CLOSE_ROUND;
         KIND_SQUARE: return CHAR_CLOSE_SQUARE;
         default:     return CHAR_CLOSE_CURLY;
      endcase
   endfunction

   function automatic kind_type random_kind();
      return kind_type'($urandom_range(0, 2));
   endfunction

   task automatic push_char(input logic [7:0] c, input logic last);
      text_char_type t;
      t.char_code = c;
      t.is_last   = last;
      text_q.push_back(t);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
   endtask

   // random well-nested string of the given pair count, nesting capped at max_depth
   task automatic add_balanced(input int pairs, input int max_depth);
      kind_type open_kinds[$];
      int       opened;
      opened = 0;
      while (opened < pairs || open_kinds.size() > 0) begin
         if (open_kinds.size() == 0 ||
             (opened < pairs && open_kinds.size() < max_depth && $urandom_range(0, 1) == 1)) begin
            open_kinds.push_back(random_kind());
            push_char(open_char(open_kinds[$]), 1'b0);
            opened++;
         end else begin
            push_char(close_char(open_kinds.pop_back()), 1'b0);
         end
      end
      text_q[text_q.size() - 1].is_last = 1'b1;
   endtask

   // fill the stack to the top, optionally push past it, then close in order
   task automatic add_deep(input int extra);
      kind_type open_kinds[$];
      for (int i = 0; i < STACK_DEPTH + extra; i++) begin
         open_kinds.push_back(random_kind());
         push_char(open_char(open_kinds[$]), 1'b0);
      end
      for (int i = 0; i < STACK_DEPTH; i++) push_char(close_char(open_kinds.pop_back()), 1'b0);
      text_q[text_q.size() - 1].is_last = 1'b1;
   endtask

   task automatic add_broken();
      int            start;
      int            pos;
      text_char_type t;
      start = text_q.size();
      add_balanced($urandom_range(1, 10), $urandom_range(1, 8));
      pos = $urandom_range(start, text_q.size() - 1);
      case ($urandom_range(0, 3))
         0: text_q[pos].char_code = 8'($urandom_range(0, 255));
         1: text_q[pos].char_code = close_char(random_kind());
         2: begin
            // unclosed: drop the final closer
            text_q.delete(text_q.size() - 1);
            text_q[text_q.size() - 1].is_last = 1'b1;
         end
         default: begin
            t.char_code = close_char(random_kind());
            t.is_last   = 1'b0;
            text_q.insert(start, t);
         end
      endcase
   endtask

   task automatic add_noise();
      int n;
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 1) == 1) begin
            if ($urandom_range(0, 1) == 1) push_char(open_char(random_kind()), i == n - 1);
            else push_char(close_char(random_kind()), i == n - 1);
         end else begin
            push_char(8'($urandom_range(0, 255)), i == n - 1);
         end
      end
   endtask

   task automatic build_stimulus();
      int strings;
      int pick;
      // directed strings
      add_text("()");
      add_text("[]");
      add_text("{}");
      add_text("({[]})");
      add_text(")");           // closer with nothing open
      add_text("(]");          // wrong closer
      add_text("(a");          // plain letter pops and fails
      push_char(8'h00, 1'b1);
      push_char(8'hFF, 1'b1);
      add_text("](");          // ignored after the string has failed
      add_text("((");          // left open at the end
      strings = 0;
      while (text_q.size() < ITEM_TARGET) begin
         strings++;
         if (strings == 25) begin
            add_deep(0);
         end else if (strings == 70) begin
            add_deep($urandom_range(1, 3));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) add_balanced($urandom_range(1, 16), $urandom_range(1, 12));
            else if (pick < 85) add_broken();
            else add_noise();
         end
      end
   endtask

   // sender
   initial begin
      req_chan.valid     <= 1'b0;
      req_chan.char_code <= 8'h00;
      req_chan.is_last   <= 1'b0;
      calm     = 1'b0;
      hold_now = 1'b0;
      build_stimulus();
      wait (!reset);
      @(posedge clock);
      for (int i = 0; i < text_q.size(); i++) begin
         if (i == 600) hold_now = 1'b1;
         if (i > (text_q.size() * 9) / 10) calm = 1'b1;
         if (!calm && $urandom_range(0, 5) == 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         req_chan.valid     <= 1'b1;
         req_chan.char_code <= text_q[i].char_code;
         req_chan.is_last   <= text_q[i].is_last;
         do @(posedge clock); while (!req_chan.ready);
      end
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // receiver: random stalls plus one long hold-off that backs up the input
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         if (hold_now) begin
            hold_now = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

endmodule

[sim.f]
hw/rtl/bbc_pkg.sv
hw/rtl/bbc_channels.sv
hw/rtl/bbc_stack_cell.sv
hw/rtl/bbc_stack_chain.sv
hw/rtl/bracket_balance_checker_top.sv
test/bracket_verdict_checker.sv
test/tb_top.sv
